### rtl/core/resd_pkg.sv
// Shared types and constants for the descending record exchange sorter.
// Used by record_exchange_sort_descending_top, resd_sort_checker and the testbench; depends on nothing.
package resd_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int SCORE_W = 12;
    localparam int AGE_W   = 7;
    localparam int TAG_W   = 16;
    localparam int REC_W   = SCORE_W + AGE_W + TAG_W;
    localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

    // One stored record; the tag sits in the low bits, the score in the high bits.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [AGE_W-1:0]   age;
        logic [TAG_W-1:0]   tag;
    } record_t;

endpackage

### rtl/core/record_exchange_sort_descending_top.sv
// Descending exchange sort of records held in one RAM; uses resd_pkg and resd_ram.
// Results of a set come out once its sort is done and then stream at one beat per
// cycle while the receiver takes them.
// Throughput: one input beat per cycle while loading; the sort's inner compare loop,
// one RAM read and one conditional write per cycle, sets the cost of a set.
// Reset: aresetn is synchronous and active low; it empties the set and clears the
// overflow flag and the output valid. The RAM itself is not cleared.
module record_exchange_sort_descending_top
    import resd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // s_tdata fields from bit 0 up: score[11:0], age[18:12], tag[34:19], zero fill.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,   // last_record
    // m_tdata fields from bit 0 up: sorted_score[11:0], sorted_age[18:12],
    // sorted_tag[34:19], zero fill.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,   // final_out
    output logic               m_tuser    // overflow
);

    // Sequencer states. The sort runs a held record for position a against every
    // later position b, reading b in the cycle before its compare.
    typedef enum logic [6:0] {
        ST_LOAD    = 7'b0000001,
        ST_SORT_A  = 7'b0000010,
        ST_SORT_AW = 7'b0000100,
        ST_SORT_B  = 7'b0001000,
        ST_SORT_WB = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_LD = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    record_t          held_reg, held_next;

    record_t          m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_last_reg, m_last_next;
    logic             m_user_reg, m_user_next;

    // RAM port signals.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    record_t          ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    record_t          rd_rec;

    // Input record unpacked from the beat.
    record_t          in_rec;
    logic             in_accept;
    logic             room;
    logic [CNT_W-1:0] count_after;
    logic             b_is_last;
    logic             out_free;

    resd_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec = record_t'(ram_rdata);

    assign in_rec.score = s_tdata[SCORE_W-1:0];
    assign in_rec.age   = s_tdata[SCORE_W+AGE_W-1:SCORE_W];
    assign in_rec.tag   = s_tdata[REC_W-1:SCORE_W+AGE_W];

    assign s_tready  = (state_reg == ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign room      = (count_reg < CNT_W'(MAX_RECORDS));
    assign count_after = room ? count_reg + CNT_W'(1) : count_reg;

    // The record whose data is on the read port is the last one of the set.
    assign b_is_last = ((CNT_W'(b_reg) + CNT_W'(1)) == count_reg);
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        held_next    = held_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = in_rec;
        ram_re    = 1'b0;
        ram_raddr = a_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_accept) begin
                    if (room) begin
                        ram_we = 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    count_next = count_after;
                    if (s_tlast) begin
                        a_next = '0;
                        // A single record needs no sort.
                        state_next = (count_after < CNT_W'(2)) ? ST_EMIT_RD : ST_SORT_A;
                    end
                end
            end
            ST_SORT_A: begin
                ram_re     = 1'b1;
                ram_raddr  = a_reg;
                state_next = ST_SORT_AW;
            end
            ST_SORT_AW: begin
                // Record at position a arrives; start reading position a + 1.
                held_next  = rd_rec;
                ram_re     = 1'b1;
                ram_raddr  = a_reg + IDX_W'(1);
                b_next     = a_reg + IDX_W'(1);
                state_next = ST_SORT_B;
            end
            ST_SORT_B: begin
                // Swap: the held record moves down to b, the larger one is held for a.
                if (held_reg.score < rd_rec.score) begin
                    ram_we    = 1'b1;
                    ram_waddr = b_reg;
                    ram_wdata = held_reg;
                    held_next = rd_rec;
                end
                if (b_is_last) begin
                    state_next = ST_SORT_WB;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = b_reg + IDX_W'(1);
                    b_next    = b_reg + IDX_W'(1);
                end
            end
            ST_SORT_WB: begin
                ram_we    = 1'b1;
                ram_waddr = a_reg;
                ram_wdata = held_reg;
                if ((CNT_W'(a_reg) + CNT_W'(2)) == count_reg) begin
                    state_next = ST_EMIT_RD;
                end else begin
                    a_next     = a_reg + IDX_W'(1);
                    state_next = ST_SORT_A;
                end
            end
            ST_EMIT_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                b_next     = '0;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                // Read data holds on the port until the output register takes it.
                if (out_free) begin
                    m_data_next  = rd_rec;
                    m_last_next  = b_is_last;
                    m_user_next  = ovf_reg;
                    m_valid_next = 1'b1;
                    if (b_is_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = b_reg + IDX_W'(1);
                        b_next    = b_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and loop index registers need no reset.
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        held_reg   <= held_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - REC_W){1'b0}}, m_data_reg.tag, m_data_reg.age,
                       m_data_reg.score};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

### rtl/core/resd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while the read enable is low. Depends on nothing.
module resd_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### dv/resd_sort_checker.sv
// Checker for the descending record sorter: predicts the sorted output of each set and
// compares it beat by beat with the result channel. Depends on resd_pkg only.
`timescale 1ns / 1ps

module resd_sort_checker
    import resd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // score, age, tag from bit 0 up, zero fill
    input  logic               s_tlast,   // last_record
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // sorted score, age, tag from bit 0 up, zero fill
    input  logic               m_tlast,   // final_out
    input  logic               m_tuser,   // overflow
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic [AGE_W-1:0]   age;
        logic [TAG_W-1:0]   tag;
        logic               final_beat;
        logic               dropped;
    } ranked_beat_t;

    record_t      open_set[$];
    logic         set_overflowed;
    ranked_beat_t ranked_q[$];
    ranked_beat_t want;

    // Store one record, or note the drop when the store is full. A closing record
    // sorts the set with the same exchange order as the block and queues its beats.
    function automatic void load_and_rank(input record_t rec, input logic closes);
        record_t      ordered [MAX_RECORDS];
        record_t      held;
        ranked_beat_t beat;
        int           n;
        if (open_set.size() < MAX_RECORDS)
            open_set.push_back(rec);
        else
            set_overflowed = 1'b1;
        if (!closes)
            return;
        n = open_set.size();
        for (int k = 0; k < n; k++)
            ordered[k] = open_set[k];
        for (int a = 0; a < n - 1; a++) begin
            for (int b = a + 1; b < n; b++) begin
                if (ordered[a].score < ordered[b].score) begin
                    held       = ordered[a];
                    ordered[a] = ordered[b];
                    ordered[b] = held;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            beat.score      = ordered[k].score;
            beat.age        = ordered[k].age;
            beat.tag        = ordered[k].tag;
            beat.final_beat = (k == n - 1);
            beat.dropped    = set_overflowed;
            ranked_q.push_back(beat);
        end
        open_set.delete();
        set_overflowed = 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            open_set.delete();
            ranked_q.delete();
            set_overflowed = 1'b0;
            mismatches     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ranked_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: score %0d age %0d tag %0h last %0b",
                                 m_tdata[SCORE_W-1:0], m_tdata[SCORE_W+AGE_W-1:SCORE_W],
                                 m_tdata[REC_W-1:SCORE_W+AGE_W], m_tlast);
                end else begin
                    want = ranked_q.pop_front();
                    if (m_tdata[SCORE_W-1:0] !== want.score ||
                        m_tdata[SCORE_W+AGE_W-1:SCORE_W] !== want.age ||
                        m_tdata[REC_W-1:SCORE_W+AGE_W] !== want.tag ||
                        m_tlast !== want.final_beat || m_tuser !== want.dropped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: want score %0d age %0d tag %0h last %0b ovf %0b",
                                     want.score, want.age, want.tag, want.final_beat,
                                     want.dropped);
                            $display("           got score %0d age %0d tag %0h last %0b ovf %0b",
                                     m_tdata[SCORE_W-1:0],
                                     m_tdata[SCORE_W+AGE_W-1:SCORE_W],
                                     m_tdata[REC_W-1:SCORE_W+AGE_W], m_tlast, m_tuser);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                load_and_rank({s_tdata[SCORE_W-1:0], s_tdata[SCORE_W+AGE_W-1:SCORE_W],
                               s_tdata[REC_W-1:SCORE_W+AGE_W]}, s_tlast);
        end
        outstanding = ranked_q.size();
    end

endmodule

### dv/tb_record_exchange_sort_descending_top.sv
// Testbench top for the descending record sorter: clock, reset, stimulus and verdict.
// Depends on resd_pkg, record_exchange_sort_descending_top and resd_sort_checker.
`timescale 1ns / 1ps

module tb_record_exchange_sort_descending_top;
    import resd_pkg::*;

    // A full set of 64 records sorting before its first result beat and the receiver
    // hold-off below both stay well under this limit, so a run that goes this long
    // without a single beat on either channel has hung.
    localparam int WATCHDOG_LIMIT = 10000;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;  // score, age, tag from bit 0 up, zero fill
    logic               s_tlast  = 1'b0; // last_record
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;        // sorted score, age, tag from bit 0 up, zero fill
    logic               m_tlast;        // final_out
    logic               m_tuser;        // overflow

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int sent;
    int set_len;

    always #5 aclk = ~aclk;

    record_exchange_sort_descending_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    resd_sort_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Result side. A hold-off request from the stimulus is taken over here and counted
    // down one cycle at a time; outside a hold-off the receiver stalls at random with
    // the probability of the current phase.
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hang detection: count cycles in which no beat moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offer one record and return at the falling edge after it was taken. The task is
    // entered at a falling edge; idle cycles before the beat drop tvalid, so a record
    // offered straight after another keeps tvalid high without a glitch.
    task automatic offer_record(input logic [SCORE_W-1:0] score, input logic [AGE_W-1:0] age,
                                input logic [TAG_W-1:0] tag, input logic closes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({tag, age, score});
        s_tlast  <= closes;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // A set of random records, the last one closing it. Scores are drawn so that ties
    // come up often, and now and then above the nominal 10.0 ceiling (2560), which the
    // block must still sort as a plain 12-bit unsigned key.
    task automatic offer_random_set(input int count);
        logic [SCORE_W-1:0] score;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0:       score = SCORE_W'($urandom_range(4) * 640);
                3:       score = SCORE_W'($urandom_range(4095));
                default: score = SCORE_W'($urandom_range(2560));
            endcase
            offer_record(score, AGE_W'($urandom_range(127)), TAG_W'($urandom_range(65535)),
                         k == count - 1);
        end
    endtask

    // Stop offering and wait until every predicted result beat has been seen.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sets, no idling. Single-record sets with every field at its top and
        // at its bottom, the top score being above the nominal range.
        offer_record(12'hFFF, 7'h7F, 16'hFFFF, 1'b1);
        offer_record(12'h000, 7'h00, 16'h0000, 1'b1);
        // Ties at the ceiling mixed with the floor and the score just below the ceiling.
        offer_record(12'd2560, 7'd1, 16'h0001, 1'b0);
        offer_record(12'd0,    7'd2, 16'h0002, 1'b0);
        offer_record(12'd2560, 7'd3, 16'h0003, 1'b0);
        offer_record(12'd2559, 7'd4, 16'h0004, 1'b1);
        // All scores equal: the output order comes only from the exchange swaps,
        // which never fire here, so the load order must come back unchanged.
        for (int k = 0; k < 5; k++)
            offer_record(12'd1280, AGE_W'(10 + k), TAG_W'(16'h1000 + k), k == 4);
        // Ascending input, the worst case for the swap count.
        offer_record(12'd0,    7'd20, 16'h2000, 1'b0);
        offer_record(12'd1,    7'd21, 16'h2001, 1'b0);
        offer_record(12'd255,  7'd22, 16'h2002, 1'b0);
        offer_record(12'd256,  7'd23, 16'h2003, 1'b0);
        offer_record(12'd2559, 7'd24, 16'h2004, 1'b0);
        offer_record(12'd2560, 7'd25, 16'h2005, 1'b1);
        // Already descending input, with one score above the nominal range.
        offer_record(12'd3000, 7'd30, 16'h3000, 1'b0);
        offer_record(12'd2560, 7'd31, 16'h3001, 1'b0);
        offer_record(12'd1,    7'd32, 16'h3002, 1'b1);
        wait_drained();

        // Capacity: a set that fills the store and runs past it, so the last three
        // records are dropped (the closing one among them) and every result beat of
        // that set must carry the overflow flag.
        offer_random_set(MAX_RECORDS + 3);
        wait_drained();

        // Back-pressure: the receiver holds off for a long stretch while small sets keep
        // coming, so the block fills up and has to stall its input.
        hold_req = 600;
        for (int k = 0; k < 3; k++)
            offer_random_set(4);
        wait_drained();

        // Random sets under four idling patterns: none, a mostly idle sender, a mostly
        // stalling receiver, and light idling on both sides. Sets are mostly short with
        // an occasional longer one.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 83 : (phase == 3) ? 7 : 0;
            recv_stall_pct = (phase == 2) ? 83 : (phase == 3) ? 7 : 0;
            sent = 0;
            while (sent < 6) begin
                set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 9)
                                                   : $urandom_range(8, 1);
                offer_random_set(set_len);
                sent += set_len;
            end
            wait_drained();
        end

        // Everything has come back; give the block time to show any stray extra beat.
        recv_stall_pct = 0;
        repeat (50) @(negedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### record_exchange_sort_descending_top.f
rtl/core/resd_pkg.sv
rtl/core/resd_ram.sv
rtl/core/record_exchange_sort_descending_top.sv
dv/resd_sort_checker.sv
dv/tb_record_exchange_sort_descending_top.sv
